[rtl/core/dib_pkg.sv]
// ----------------------------------------------------------------------------
// dib_pkg
// Shared widths, register indexes and types for the debounced input bank.
// ----------------------------------------------------------------------------
package dib_pkg;

    localparam int NUM_INPUTS = 8;
    localparam int NUM_TYPES  = 16;
    localparam int TYPE_W     = 4;
    localparam int TIMER_W    = 31;
    localparam int RAW_W      = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TYPES_W    = NUM_INPUTS * TYPE_W;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_BITS    = RAW_W + TIMER_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = NUM_INPUTS + 2 * NUM_TYPES;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE_TIME = 2'd0,
        CFG_INV_MASK    = 2'd1,
        CFG_INPUT_TYPES = 2'd2
    } t_cfg_idx;

    typedef logic [TIMER_W-1:0]    t_timer;
    typedef logic [NUM_TYPES-1:0]  t_type_mask;

endpackage

[rtl/core/dib_lane.sv]
// ----------------------------------------------------------------------------
// dib_lane
// One input channel: change timer and debounced state.
// ----------------------------------------------------------------------------
module dib_lane (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_level,
    input  dib_pkg::t_timer  i_step,
    input  dib_pkg::t_timer  i_settle_time,
    output logic             o_state_nxt,
    output logic             o_state
);

    dib_pkg::t_timer            r_timer;
    dib_pkg::t_timer            n_timer;
    logic                       r_state;
    logic                       n_state;
    logic [dib_pkg::TIMER_W:0]  w_sum;
    dib_pkg::t_timer            w_sat;

    always_comb begin
        w_sum = {1'b0, r_timer} + {1'b0, i_step};
        // saturate at the timer's full scale
        w_sat = w_sum[dib_pkg::TIMER_W] ? '1 : w_sum[dib_pkg::TIMER_W-1:0];
        n_state = r_state;
        n_timer = '0;
        if (i_level != r_state) begin
            if (w_sat >= i_settle_time) begin
                n_state = i_level;
            end else begin
                n_timer = w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_state <= 1'b0;
        end else if (i_en) begin
            r_timer <= n_timer;
            r_state <= n_state;
        end
    end

    assign o_state_nxt = n_state;
    assign o_state     = r_state;

endmodule

[rtl/core/dib_type_mask.sv]
// ----------------------------------------------------------------------------
// dib_type_mask
// Builds the per-type "on" and "present" summary masks.
// ----------------------------------------------------------------------------
module dib_type_mask (
    input  logic [dib_pkg::NUM_INPUTS-1:0] i_states,
    input  logic [dib_pkg::TYPES_W-1:0]    i_types,
    output dib_pkg::t_type_mask            o_on_mask,
    output dib_pkg::t_type_mask            o_present_mask
);

    logic [dib_pkg::TYPE_W-1:0] w_code;

    always_comb begin
        o_on_mask      = '0;
        o_present_mask = '0;
        w_code         = '0;
        for (int i = 0; i < dib_pkg::NUM_INPUTS; i++) begin
            w_code = i_types[i*dib_pkg::TYPE_W +: dib_pkg::TYPE_W];
            // codes past the last type contribute nothing
            if ({1'b0, w_code} < (dib_pkg::TYPE_W+1)'(dib_pkg::NUM_TYPES)) begin
                o_present_mask[w_code] = 1'b1;
                if (i_states[i]) begin
                    o_on_mask[w_code] = 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/debounced_input_bank.sv]
// ----------------------------------------------------------------------------
// debounced_input_bank
// Time-accumulating debounce of eight digital inputs with per-type masks.
// ----------------------------------------------------------------------------
// Path: the input register, then the lane update into the result register;
//   all lanes update in parallel.
// Throughput: one tick per cycle while m_axis_tready keeps the result moving.
// Reset (synchronous, i_rst_n low): clears debounced states, timers,
//   configuration registers and both valid flags.
// ----------------------------------------------------------------------------
module debounced_input_bank (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [dib_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dib_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input ticks
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] raw_levels, [38:8] time_step, [39] zero
    input  logic [dib_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] debounced, [23:8] type_on_mask, [39:24] type_present_mask
    output logic [dib_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    // configuration registers
    dib_pkg::t_timer                r_settle_time;
    logic [dib_pkg::RAW_W-1:0]      r_inv_mask;
    logic [dib_pkg::TYPES_W-1:0]    r_types;

    // input register
    logic                           r_in_vld;
    logic [dib_pkg::RAW_W-1:0]      r_raw;
    dib_pkg::t_timer                r_step;

    // result register
    logic                           r_out_vld;
    logic [dib_pkg::NUM_INPUTS-1:0] r_deb;
    dib_pkg::t_type_mask            r_on;
    dib_pkg::t_type_mask            r_present;

    logic                           w_adv;
    logic [dib_pkg::NUM_INPUTS-1:0] w_state_nxt;
    logic [dib_pkg::NUM_INPUTS-1:0] w_state;
    dib_pkg::t_type_mask            w_on;
    dib_pkg::t_type_mask            w_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_time <= '0;
            r_inv_mask    <= '0;
            r_types       <= '0;
        end else if (i_cfg_we) begin
            case (dib_pkg::t_cfg_idx'(i_cfg_idx))
                dib_pkg::CFG_SETTLE_TIME: r_settle_time <= i_cfg_data[dib_pkg::TIMER_W-1:0];
                dib_pkg::CFG_INV_MASK:    r_inv_mask    <= i_cfg_data[dib_pkg::RAW_W-1:0];
                dib_pkg::CFG_INPUT_TYPES: r_types       <= i_cfg_data[dib_pkg::TYPES_W-1:0];
                default: ;
            endcase
        end
    end

    // compute stage moves when it holds a tick and the result slot is free or being drained
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_raw  <= s_axis_tdata[dib_pkg::RAW_W-1:0];
            r_step <= s_axis_tdata[dib_pkg::RAW_W +: dib_pkg::TIMER_W];
        end
    end

    for (genvar g = 0; g < dib_pkg::NUM_INPUTS; g++) begin : g_lane
        dib_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (w_adv),
            .i_level       (r_raw[g] ^ r_inv_mask[g]),
            .i_step        (r_step),
            .i_settle_time (r_settle_time),
            .o_state_nxt   (w_state_nxt[g]),
            .o_state       (w_state[g])
        );
    end

    dib_type_mask u_type_mask (
        .i_states       (w_state_nxt),
        .i_types        (r_types),
        .o_on_mask      (w_on),
        .o_present_mask (w_present)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_deb     <= w_state_nxt;
            r_on      <= w_on;
            r_present <= w_present;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = dib_pkg::OUT_TDATA_W'({r_present, r_on, r_deb});

    // lane state only moves on a compute-stage transfer
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_state))
        else $error("debounced state changed without a transfer");

    // reported states match the lane registers right after an update
    a_deb_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_deb == w_state))
        else $error("result debounced field differs from lane state");

    // an input that is on must also mark its type present
    a_on_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_on & ~r_present) == '0))
        else $error("type on mask not within present mask");

    // stalling upstream only when a tick is held
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_vld && r_out_vld))
        else $error("input stalled with free slots");

endmodule
